/* hw/rtl/stt_pkg.sv */
// ----------------------------------------------------------------------------
// stt_pkg: shared constants and types of the system tick timer
// Count width, bit-serial run length, field widths, commands, register
// indexes and the control group of the remainder unit.
// ----------------------------------------------------------------------------
package stt_pkg;

    // Width of the wrapping tick count
    localparam int COUNT_WIDTH = 32;

    // Serial run length: covers the count and the 32-bit input fields
    localparam int SER_W  = (COUNT_WIDTH > 32) ? COUNT_WIDTH : 32;
    localparam int STEP_W = $clog2(SER_W);

    // Field widths
    localparam int FIELD_W  = 32;
    localparam int REG_W    = 16;
    localparam int PHASE_W  = 17;

    // Timeout start keeps the low 32 bits of the count only
    localparam logic [COUNT_WIDTH-1:0] START_MASK =
        {COUNT_WIDTH{1'b1}} >> ((COUNT_WIDTH > 32) ? (COUNT_WIDTH - 32) : 0);

    // Commands
    localparam logic [1:0] CMD_TICK    = 2'd0;
    localparam logic [1:0] CMD_RESTART = 2'd1;
    localparam logic [1:0] CMD_QUERY   = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] REG_EVENT_ENABLE = 2'd0;
    localparam logic [1:0] REG_EVENT_PERIOD = 2'd1;
    localparam logic [1:0] REG_LED_OFF      = 2'd2;
    localparam logic [1:0] REG_LED_ON       = 2'd3;

    // Control of the serial remainder unit
    typedef struct packed {
        logic load;
        logic shift;
    } stt_ser_ctrl_t;

endpackage

/* hw/rtl/stt_mod_unit.sv */
// ----------------------------------------------------------------------------
// stt_mod_unit: bit-serial remainder of the tick count by the event period
// Restoring division, one dividend bit per cycle while shifting, MSB first.
// ----------------------------------------------------------------------------
module stt_mod_unit
    import stt_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  stt_ser_ctrl_t      ctrl,
    input  logic [SER_W-1:0]   dividend,
    input  logic [REG_W-1:0]   divisor,
    output logic               rem_zero
);

    logic [SER_W-1:0] div_sr_reg;
    logic [SER_W-1:0] div_sr_next;
    logic [REG_W-1:0] rem_reg;
    logic [REG_W-1:0] rem_next;
    logic [REG_W:0]   rem_shift;
    logic [REG_W:0]   rem_sub;

    // Bring down the next bit and subtract the divisor where it fits
    always_comb
    begin
        rem_shift = {rem_reg, div_sr_reg[SER_W-1]};
        rem_sub   = rem_shift - {1'b0, divisor};
        rem_next  = rem_reg;
        div_sr_next = div_sr_reg;
        if (ctrl.load)
        begin
            rem_next    = '0;
            div_sr_next = dividend;
        end
        else if (ctrl.shift)
        begin
            div_sr_next = {div_sr_reg[SER_W-2:0], 1'b0};
            if (rem_shift >= {1'b0, divisor})
            begin
                rem_next = rem_sub[REG_W-1:0];
            end
            else
            begin
                rem_next = rem_shift[REG_W-1:0];
            end
        end
    end

    // Hold the partial remainder and the dividend shift line
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg    <= '0;
            div_sr_reg <= '0;
        end
        else
        begin
            rem_reg    <= rem_next;
            div_sr_reg <= div_sr_next;
        end
    end

    assign rem_zero = (rem_reg == '0);

endmodule

/* hw/rtl/system_tick_timer.sv */
// ----------------------------------------------------------------------------
// system_tick_timer: tick count with periodic event, LED blinker and timeout
// Each request reports the count, event, LED level, timeout state and the
// ticks elapsed since a given start.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+--------------------------------
//  in      | into      | in_valid / in_stall  | cmd, timeout_length, from_tick
//  out     | out of    | out_valid / out_stall| tick_count, event_fire, led_lit,
//          |           |                      | timeout_done, elapsed
//  cfg     | into      | cfg_valid / cfg_ready| cfg_index, cfg_data
//
//  A request is accepted, then runs the bit-serial steps of the remainder
//  unit and the two serial subtractors, then loads the result register.
//  A waiting result does not block the next request; the result register is
//  loaded once it is empty or being taken. Configuration is always ready.
//  Reset clears the count, the LED phase, the timeout and the control and
//  configuration registers, but not the serial lines or the result register.
// ----------------------------------------------------------------------------
module system_tick_timer
    import stt_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    // request channel
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [1:0]          cmd,
    input  logic [FIELD_W-1:0]  timeout_length,
    input  logic [FIELD_W-1:0]  from_tick,
    // result channel
    output logic                out_valid,
    input  logic                out_stall,
    output logic [FIELD_W-1:0]  tick_count,
    output logic                event_fire,
    output logic                led_lit,
    output logic                timeout_done,
    output logic [FIELD_W-1:0]  elapsed,
    // configuration channel
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [REG_W-1:0]    cfg_data
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(SER_W - 1);
    localparam logic [STEP_W:0]   CNT_LIM   = (STEP_W + 1)'(COUNT_WIDTH);

    // Configuration registers
    logic               ev_en_reg;
    logic [REG_W-1:0]   ev_period_reg;
    logic [REG_W-1:0]   led_off_reg;
    logic [REG_W-1:0]   led_on_reg;

    // Architectural state
    logic [COUNT_WIDTH-1:0] counter_reg;
    logic [COUNT_WIDTH-1:0] counter_next;
    logic [PHASE_W-1:0]     phase_reg;
    logic [PHASE_W-1:0]     phase_next;
    logic [COUNT_WIDTH-1:0] tstart_reg;
    logic [COUNT_WIDTH-1:0] tstart_next;
    logic [FIELD_W-1:0]     tlen_reg;
    logic [FIELD_W-1:0]     tlen_next;

    // Sequencer
    logic [1:0]         state_reg;
    logic [1:0]         state_next;
    logic [STEP_W-1:0]  step_reg;
    logic [STEP_W-1:0]  step_next;
    logic               tick_item_reg;
    logic               tick_item_next;

    // Serial subtractors, least significant bit first
    logic [SER_W-1:0]   cnt_sr_reg;
    logic [SER_W-1:0]   cnt_sr_next;
    logic [SER_W-1:0]   st_sr_reg;
    logic [SER_W-1:0]   st_sr_next;
    logic [SER_W-1:0]   ts_sr_reg;
    logic [SER_W-1:0]   ts_sr_next;
    logic [SER_W-1:0]   len_sr_reg;
    logic [SER_W-1:0]   len_sr_next;
    logic [SER_W-1:0]   el_sr_reg;
    logic [SER_W-1:0]   el_sr_next;
    logic               bor_e_reg;
    logic               bor_e_next;
    logic               bor_t_reg;
    logic               bor_t_next;
    logic               ge_reg;
    logic               ge_next;

    // Result register
    logic               out_valid_reg;
    logic               out_valid_next;
    logic [FIELD_W-1:0] tick_count_reg;
    logic               event_fire_reg;
    logic               led_lit_reg;
    logic               timeout_done_reg;
    logic [FIELD_W-1:0] elapsed_reg;

    logic               in_accept;
    logic               out_free;
    logic               load_out;
    logic [PHASE_W-1:0] blink_len;
    logic [PHASE_W-1:0] phase_base;
    logic               in_range;
    logic               bit_a;
    logic               bit_e;
    logic               bit_t;
    logic               diff_e;
    logic               diff_t;
    logic               rem_zero;
    stt_ser_ctrl_t      mod_ctrl;

    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign load_out  = (state_reg == ST_DONE) && out_free;
    assign in_stall  = (state_reg != ST_IDLE);
    assign cfg_ready = 1'b1;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ev_en_reg     <= 1'b0;
            ev_period_reg <= '0;
            led_off_reg   <= '0;
            led_on_reg    <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_EVENT_ENABLE: ev_en_reg     <= cfg_data[0];
                REG_EVENT_PERIOD: ev_period_reg <= cfg_data;
                REG_LED_OFF:      led_off_reg   <= cfg_data;
                REG_LED_ON:       led_on_reg    <= cfg_data;
                default:          ev_en_reg     <= ev_en_reg;
            endcase
        end
    end

    // Advance count and blink phase on a tick, restart the timeout on a restart
    always_comb
    begin
        blink_len    = {1'b0, led_off_reg} + {1'b0, led_on_reg};
        phase_base   = (phase_reg >= blink_len) ? '0 : phase_reg;
        counter_next = counter_reg;
        phase_next   = phase_reg;
        tstart_next  = tstart_reg;
        tlen_next    = tlen_reg;
        tick_item_next = tick_item_reg;
        if (in_accept)
        begin
            tick_item_next = (cmd == CMD_TICK);
            case (cmd)
                CMD_TICK:
                begin
                    counter_next = counter_reg + 1'b1;
                    phase_next   = phase_base + 1'b1;
                end
                CMD_RESTART:
                begin
                    tstart_next = counter_reg & START_MASK;
                    tlen_next   = timeout_length;
                end
                default:
                begin
                    counter_next = counter_reg;
                end
            endcase
        end
    end

    // Serial subtract and compare, one bit per step
    always_comb
    begin
        in_range = ({1'b0, step_reg} < CNT_LIM);
        bit_a    = cnt_sr_reg[0];
        bit_e    = st_sr_reg[0];
        bit_t    = ts_sr_reg[0];
        diff_e   = (bit_a ^ bit_e ^ bor_e_reg) & in_range;
        diff_t   = (bit_a ^ bit_t ^ bor_t_reg) & in_range;

        cnt_sr_next = cnt_sr_reg;
        st_sr_next  = st_sr_reg;
        ts_sr_next  = ts_sr_reg;
        len_sr_next = len_sr_reg;
        el_sr_next  = el_sr_reg;
        bor_e_next  = bor_e_reg;
        bor_t_next  = bor_t_reg;
        ge_next     = ge_reg;

        if (in_accept)
        begin
            cnt_sr_next = SER_W'(counter_next);
            st_sr_next  = SER_W'(from_tick);
            ts_sr_next  = SER_W'(tstart_next);
            len_sr_next = SER_W'(tlen_next);
            bor_e_next  = 1'b0;
            bor_t_next  = 1'b0;
            ge_next     = 1'b1;
        end
        else if (state_reg == ST_RUN)
        begin
            cnt_sr_next = {1'b0, cnt_sr_reg[SER_W-1:1]};
            st_sr_next  = {1'b0, st_sr_reg[SER_W-1:1]};
            ts_sr_next  = {1'b0, ts_sr_reg[SER_W-1:1]};
            len_sr_next = {1'b0, len_sr_reg[SER_W-1:1]};
            el_sr_next  = {diff_e, el_sr_reg[SER_W-1:1]};
            bor_e_next  = (!bit_a && bit_e) || (!bit_a && bor_e_reg) || (bit_e && bor_e_reg);
            bor_t_next  = (!bit_a && bit_t) || (!bit_a && bor_t_reg) || (bit_t && bor_t_reg);
            if (diff_t != len_sr_reg[0])
            begin
                ge_next = diff_t;
            end
        end
    end

    // Sequence accept, serial run and result load
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = ST_RUN;
                    step_next  = '0;
                end
            end
            ST_RUN:
            begin
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_LAST)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign mod_ctrl.load  = in_accept;
    assign mod_ctrl.shift = (state_reg == ST_RUN);

    stt_mod_unit u_mod
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (mod_ctrl),
        .dividend (SER_W'(counter_next)),
        .divisor  (ev_period_reg),
        .rem_zero (rem_zero)
    );

    // Drop the result valid once taken, raise it on load
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
    end

    // Hold control and state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            tick_item_reg <= 1'b0;
            counter_reg   <= '0;
            phase_reg     <= '0;
            tstart_reg    <= '0;
            tlen_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            tick_item_reg <= tick_item_next;
            counter_reg   <= counter_next;
            phase_reg     <= phase_next;
            tstart_reg    <= tstart_next;
            tlen_reg      <= tlen_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Advance serial shift lines
    always_ff @(posedge clk)
    begin
        cnt_sr_reg <= cnt_sr_next;
        st_sr_reg  <= st_sr_next;
        ts_sr_reg  <= ts_sr_next;
        len_sr_reg <= len_sr_next;
        el_sr_reg  <= el_sr_next;
        bor_e_reg  <= bor_e_next;
        bor_t_reg  <= bor_t_next;
        ge_reg     <= ge_next;
    end

    // Load the result register
    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            tick_count_reg   <= FIELD_W'(counter_reg);
            event_fire_reg   <= tick_item_reg && ev_en_reg &&
                                ((ev_period_reg == '0) || rem_zero);
            led_lit_reg      <= (phase_reg > {1'b0, led_off_reg});
            timeout_done_reg <= ge_reg;
            elapsed_reg      <= FIELD_W'(el_sr_reg);
        end
    end

    assign out_valid    = out_valid_reg;
    assign tick_count   = tick_count_reg;
    assign event_fire   = event_fire_reg;
    assign led_lit      = led_lit_reg;
    assign timeout_done = timeout_done_reg;
    assign elapsed      = elapsed_reg;

endmodule

/* hw/rtl/stt_checker.sv */
// ----------------------------------------------------------------------------
// stt_checker: port-level checks of the system tick timer
// Watches the request and result handshakes over time.
// ----------------------------------------------------------------------------
module stt_checker
    import stt_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_stall,
    input  logic                out_valid,
    input  logic                out_stall,
    input  logic [FIELD_W-1:0]  tick_count
);

    // Hold a stalled result
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(tick_count))
        else $error("stalled result changed");

    // An accepted request keeps the block busy on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("request taken without going busy");

    // A result appears only from a request in progress
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result without a request in progress");

endmodule

bind system_tick_timer stt_checker u_stt_checker
(
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .tick_count (tick_count)
);
